FILE: design/lfpr_pkg.sv
// Shared constants, types and the fixed reply table of the length-framed packet responder.
`timescale 1ns / 1ps
`default_nettype none
package lfpr_pkg;

  // Frames longer than BUFFER_DEPTH-1 bytes are consumed and dropped
  localparam int BUFFER_DEPTH      = 128;
  localparam int PAYLOAD_BYTES_DEF = 8;

  // Frame type codes
  localparam logic [7:0] TYPE_HUB = 8'h09;
  localparam logic [7:0] TYPE_MOD = 8'h18;

  // Transmit links
  localparam logic LINK_A = 1'b0;
  localparam logic LINK_B = 1'b1;

  // Reply kinds
  localparam logic KIND_HUB = 1'b0;
  localparam logic KIND_MOD = 1'b1;

  // Fixed reply bytes
  localparam int         HUB_TABLE_LEN = 10;
  localparam logic [7:0] HUB_ECHO_LEN  = 8'h02;
  localparam logic [7:0] MOD_HEAD      = 8'h0a;

  // Reply request from the frame parser to the reply sequencer
  typedef struct packed {
    logic load;
    logic kind;
  } lfpr_req_t;

  // Ten-byte table sent on link A for a hub frame
  function automatic logic [7:0] hub_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h0a;
      4'd1:    val = 8'h18;
      4'd5:    val = 8'h01;
      4'd7:    val = 8'h01;
      4'd9:    val = 8'h01;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

FILE: design/lfpr_parse.sv
// Frame parser: tracks length, type and payload of the byte stream and raises reply requests.
`timescale 1ns / 1ps
`default_nettype none
module lfpr_parse #(
  parameter int PAYLOAD_BYTES = lfpr_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_rx_byte,
  input  wire logic                           reply_busy,
  output lfpr_pkg::lfpr_req_t                 req,
  output logic [PAYLOAD_BYTES-1:0][7:0]       snap
);

  logic [7:0] count_r, count_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] type_r, type_nxt;
  logic [PAYLOAD_BYTES-1:0][7:0] store_r, store_nxt;

  logic       acc;
  logic       near_end;
  logic       too_long;
  logic       long_enough;
  logic [7:0] type_cur;
  logic [7:0] offset;

  // Hold the byte that would finish a frame while the reply sequencer is busy with the previous reply
  assign near_end = (count_r != 8'd0) && ((count_r + 8'd1) == len_r);
  assign in_stall = reply_busy && near_end;
  assign acc      = in_valid && !in_stall;

  assign type_cur    = (count_r == 8'd1) ? in_rx_byte : type_r;
  assign offset      = count_r - 8'd2;
  assign too_long    = {1'b0, len_r} > 9'(lfpr_pkg::BUFFER_DEPTH - 1);
  assign long_enough = {1'b0, len_r} >= 9'(2 + PAYLOAD_BYTES);

  // Advance the frame state on each accepted byte
  always_comb begin
    count_nxt = count_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    store_nxt = store_r;
    if (acc) begin
      if (count_r == 8'd0) begin
        len_nxt   = in_rx_byte;
        type_nxt  = 8'd0;
        count_nxt = (in_rx_byte >= 8'd2) ? 8'd1 : 8'd0;
      end else begin
        type_nxt = type_cur;
        for (int e = 0; e < PAYLOAD_BYTES; e++) begin
          if (count_r >= 8'd2 && offset == 8'(e)) begin
            store_nxt[e] = in_rx_byte;
          end
        end
        count_nxt = near_end ? 8'd0 : count_r + 8'd1;
      end
    end
  end

  // Raise a reply for complete frames of a known type and a legal length
  always_comb begin
    req.kind = (type_cur == lfpr_pkg::TYPE_HUB) ? lfpr_pkg::KIND_HUB : lfpr_pkg::KIND_MOD;
    req.load = acc && near_end && !too_long &&
               ((type_cur == lfpr_pkg::TYPE_HUB) ||
                (type_cur == lfpr_pkg::TYPE_MOD && long_enough));
  end

  // Hand the payload over including a byte written this cycle
  assign snap = store_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 8'd0;
      len_r   <= 8'd0;
      type_r  <= 8'd0;
    end else begin
      count_r <= count_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

endmodule
`default_nettype wire

FILE: design/lfpr_reply.sv
// Reply sequencer: walks one reply byte by byte into the output register.
`timescale 1ns / 1ps
`default_nettype none
module lfpr_reply #(
  parameter int PAYLOAD_BYTES = lfpr_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lfpr_pkg::lfpr_req_t            req,
  input  wire logic [PAYLOAD_BYTES-1:0][7:0]  snap,
  output logic                                busy,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_tx_link,
  output logic [7:0]                          out_tx_byte,
  output logic                                out_last
);

  localparam int LAST_HUB = lfpr_pkg::HUB_TABLE_LEN + 1;
  localparam int LAST_MOD = PAYLOAD_BYTES + 1;
  localparam int IDX_MAX  = (LAST_HUB > LAST_MOD) ? LAST_HUB : LAST_MOD;
  localparam int IW       = $clog2(IDX_MAX + 1);

  logic                          busy_r, busy_nxt;
  logic                          kind_r, kind_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic [PAYLOAD_BYTES-1:0][7:0] snap_r, snap_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_link_r, out_link_nxt;
  logic [7:0]                    out_byte_r, out_byte_nxt;
  logic                          out_last_r, out_last_nxt;

  logic       adv;
  logic       cur_link;
  logic [7:0] cur_byte;
  logic       cur_last;

  // Move a byte into the output register whenever it is free or being taken
  assign adv = busy_r && (!out_valid_r || !out_stall);

  // Select the current reply byte
  always_comb begin
    cur_link = lfpr_pkg::LINK_A;
    cur_byte = 8'd0;
    cur_last = 1'b0;
    case (kind_r)
      lfpr_pkg::KIND_HUB: begin
        if (idx_r < IW'(lfpr_pkg::HUB_TABLE_LEN)) begin
          cur_byte = lfpr_pkg::hub_byte(idx_r[3:0]);
        end else if (idx_r == IW'(lfpr_pkg::HUB_TABLE_LEN)) begin
          cur_link = lfpr_pkg::LINK_B;
          cur_byte = lfpr_pkg::HUB_ECHO_LEN;
        end else begin
          cur_link = lfpr_pkg::LINK_B;
          cur_byte = lfpr_pkg::TYPE_HUB;
          cur_last = 1'b1;
        end
      end
      default: begin
        if (idx_r == IW'(0)) begin
          cur_byte = lfpr_pkg::MOD_HEAD;
        end else if (idx_r == IW'(1)) begin
          cur_byte = lfpr_pkg::TYPE_MOD;
        end else begin
          cur_byte = snap_r[0];
          cur_last = (idx_r == IW'(LAST_MOD));
        end
      end
    endcase
  end

  // Load a new request or step through the current one
  always_comb begin
    busy_nxt      = busy_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    snap_nxt      = snap_r;
    out_valid_nxt = out_valid_r;
    out_link_nxt  = out_link_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (req.load) begin
      busy_nxt = 1'b1;
      kind_nxt = req.kind;
      idx_nxt  = '0;
      snap_nxt = snap;
    end else if (adv) begin
      idx_nxt = idx_r + IW'(1);
      if (kind_r == lfpr_pkg::KIND_MOD && idx_r >= IW'(2)) begin
        snap_nxt = snap_r >> 8;
      end
      if (cur_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_link_nxt  = cur_link;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = cur_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      kind_r      <= lfpr_pkg::KIND_HUB;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      kind_r      <= kind_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r     <= snap_nxt;
    out_link_r <= out_link_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy        = busy_r;
  assign out_valid   = out_valid_r;
  assign out_tx_link = out_link_r;
  assign out_tx_byte = out_byte_r;
  assign out_last    = out_last_r;

  // A new request never lands on a reply still in progress
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.load && busy_r))
    else $error("reply request while sequencer busy");

  // The sequencer goes idle only after its final byte entered the output register
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (out_valid_r && out_last_r))
    else $error("sequencer idle without final byte");

  // The byte index never runs past the end of the reply
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((kind_r == lfpr_pkg::KIND_HUB && idx_r <= IW'(LAST_HUB)) ||
                (kind_r == lfpr_pkg::KIND_MOD && idx_r <= IW'(LAST_MOD))))
    else $error("reply index out of range");

endmodule
`default_nettype wire

FILE: design/length_framed_packet_responder_top.sv
// Top level of the length-framed packet responder.
// Received bytes are taken at one per cycle and cut into frames (first byte total
// length, second byte type). A type 0x09 frame is answered with twelve bytes (ten
// table bytes on link A, then 02 09 on link B); a type 0x18 frame of at least
// 2+PAYLOAD_BYTES bytes with 0a 18 and its first PAYLOAD_BYTES payload bytes on
// link A. Other frames, lengths below two and lengths above BUFFER_DEPTH-1 are
// consumed without reply. The reply is loaded into the sequencer when the frame's
// last byte is accepted and leaves at one byte per cycle unless out_stall holds
// it. The input takes a byte every cycle, except that the byte closing a frame is
// stalled while the reply sequencer is still sending the previous reply: the
// single sequencer sets that limit.
`timescale 1ns / 1ps
`default_nettype none
module length_framed_packet_responder_top #(
  parameter int PAYLOAD_BYTES = lfpr_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_tx_link,
  output logic [7:0]      out_tx_byte,
  output logic            out_last
);

  lfpr_pkg::lfpr_req_t           req;
  logic [PAYLOAD_BYTES-1:0][7:0] snap;
  logic                          reply_busy;

  // Parse the byte stream into frames
  lfpr_parse #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .reply_busy (reply_busy),
    .req        (req),
    .snap       (snap)
  );

  // Send the replies
  lfpr_reply #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_reply (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .snap        (snap),
    .busy        (reply_busy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_tx_link (out_tx_link),
    .out_tx_byte (out_tx_byte),
    .out_last    (out_last)
  );

endmodule
`default_nettype wire
